// ===== rtl/longest_unique_run_length_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the longest unique run length block.
// ---------------------------------------------------------------------------
`ifndef LONGEST_UNIQUE_RUN_LENGTH_MACROS_SVH
`define LONGEST_UNIQUE_RUN_LENGTH_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define LUR_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled in reset.
`define LUR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
// Next-cycle implication that is checked in reset too.
`define LUR_ASSERT_RESET(label, clk_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LUR_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg)
`define LUR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)
`define LUR_ASSERT_RESET(label, clk_s, ante, cons, msg)
`endif
`endif

// ===== rtl/lur_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lur_pkg
// Shared types and constants for the longest unique run length block.
// ---------------------------------------------------------------------------
package lur_pkg;

  localparam int CHAR_W        = 8;
  localparam int OUT_W         = 16;
  localparam int POS_BITS_DEF  = 16;
  localparam int CHAR_BITS_DEF = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              has_char;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] longest_length;
    logic             overflow;
  } out_item_t;

  // Table controls issued by the tracker for the item in the lookup stage.
  typedef struct packed {
    logic wr_en;
    logic clr;
  } tbl_ctrl_t;

endpackage

// ===== rtl/lur_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lur_table
// Last-seen position memory with per-entry seen bits and write forwarding.
// ---------------------------------------------------------------------------
module lur_table #(
  parameter int POS_BITS  = lur_pkg::POS_BITS_DEF,
  parameter int CHAR_BITS = lur_pkg::CHAR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [CHAR_BITS-1:0]  rd_addr,
  input  lur_pkg::tbl_ctrl_t    ctrl,
  input  logic [POS_BITS-1:0]   wr_pos,
  output logic                  seen,
  output logic [POS_BITS-1:0]   last_pos
);
  import lur_pkg::*;

  localparam int DEPTH = 1 << CHAR_BITS;

  logic [POS_BITS-1:0]  mem [DEPTH];
  logic [POS_BITS-1:0]  rd_data;
  logic [DEPTH-1:0]     seen_valid;
  logic [CHAR_BITS-1:0] stage_addr;
  logic                 fwd_hit;
  logic [POS_BITS-1:0]  fwd_pos;

  // Write at the address of the item in the lookup stage; read for the next one.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[stage_addr] <= wr_pos;
    end
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      stage_addr <= rd_addr;
      // Bypass the write that lands on the same entry at this edge.
      fwd_hit    <= ctrl.wr_en && (stage_addr == rd_addr);
      fwd_pos    <= wr_pos;
    end
  end

  // Clear after the byte write: the closing byte does not survive the string.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      seen_valid <= '0;
    end else if (ctrl.wr_en) begin
      seen_valid[stage_addr] <= 1'b1;
    end
  end

  assign seen     = seen_valid[stage_addr];
  assign last_pos = fwd_hit ? fwd_pos : rd_data;

endmodule

// ===== rtl/lur_track.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lur_track
// Window start, position and best length registers with their update.
// ---------------------------------------------------------------------------
module lur_track #(
  parameter int POS_BITS = lur_pkg::POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  commit,
  input  logic                  has_char,
  input  logic                  end_of_string,
  input  logic                  seen,
  input  logic [POS_BITS-1:0]   last_pos,
  output lur_pkg::tbl_ctrl_t    ctrl,
  output logic [POS_BITS-1:0]   wr_pos,
  output lur_pkg::out_item_t    result
);
  import lur_pkg::*;

  logic [POS_BITS-1:0] window_start, window_start_next;
  logic [POS_BITS-1:0] current_position, current_position_next;
  logic [POS_BITS-1:0] best_length, best_length_next;
  logic                overflow_seen, overflow_seen_next;
  logic [POS_BITS-1:0] ws_upd;
  logic [POS_BITS-1:0] run;
  logic                full;
  logic                take;
  logic                sat;

  always_comb begin
    full   = (current_position == {POS_BITS{1'b1}});
    take   = has_char && !full;
    ws_upd = (seen && (last_pos >= window_start)) ? last_pos + 1'b1 : window_start;
    run    = current_position - ws_upd + 1'b1;

    window_start_next     = window_start;
    current_position_next = current_position;
    best_length_next      = best_length;
    overflow_seen_next    = overflow_seen || (has_char && full);
    if (take) begin
      window_start_next     = ws_upd;
      current_position_next = current_position + 1'b1;
      if (run > best_length) begin
        best_length_next = run;
      end
    end
  end

  // Saturate to the output width.
  always_comb begin
    sat                   = (best_length_next >> OUT_W) != '0;
    result.longest_length = sat ? {OUT_W{1'b1}} : OUT_W'(best_length_next);
    result.overflow       = overflow_seen_next || sat;
  end

  assign ctrl.wr_en = commit && take;
  assign ctrl.clr   = commit && end_of_string;
  assign wr_pos     = current_position;

  always_ff @(posedge clk) begin
    if (rst || (commit && end_of_string)) begin
      window_start     <= '0;
      current_position <= '0;
      best_length      <= '0;
      overflow_seen    <= 1'b0;
    end else if (commit) begin
      window_start     <= window_start_next;
      current_position <= current_position_next;
      best_length      <= best_length_next;
      overflow_seen    <= overflow_seen_next;
    end
  end

endmodule

// ===== rtl/longest_unique_run_length.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// longest_unique_run_length
// Streams a string one byte per beat and returns the length of its longest
// run with no repeated byte, using a last-seen position table.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | sink      | in_valid / in_stall       | in_data  (char, flags)
//  out     | source    | out_valid / out_stall     | out_data (length, overflow)
//
//  One beat per cycle sustained while in_stall is low; the result of a closing
//  beat is loaded into the output register as the beat leaves the lookup
//  stage. The limit is the table read-modify-write: the read is issued when
//  a beat is taken, the write lands as the beat leaves the lookup stage and
//  is forwarded to a read of the same entry issued at the same edge.
//  Reset (rst, synchronous) empties the lookup stage and the output register
//  and clears all seen bits at once; no clearing pass follows.
//  in_stall rises only when a string-closing beat waits in the lookup stage
//  while the output register holds a result that is not yet taken.
//
module longest_unique_run_length #(
  parameter int POS_BITS  = lur_pkg::POS_BITS_DEF,
  parameter int CHAR_BITS = lur_pkg::CHAR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lur_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lur_pkg::out_item_t out_data
);
  import lur_pkg::*;
  `include "longest_unique_run_length_macros.svh"

  // Lookup stage: the item whose table read is in flight.
  logic      s1_valid;
  logic      s1_has_char;
  logic      s1_eos;
  logic      s1_adv;
  logic      accept;
  logic      res_load;
  logic      res_take;

  tbl_ctrl_t           ctrl;
  logic                seen;
  logic [POS_BITS-1:0] last_pos;
  logic [POS_BITS-1:0] wr_pos;
  out_item_t           result;

  // Advance unless a result must go out and the output register is blocked.
  assign s1_adv   = s1_valid && (!s1_eos || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign res_load = s1_adv && s1_eos;
  assign res_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Hold the beat's flags alongside its table read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_has_char <= in_data.has_char;
      s1_eos      <= in_data.end_of_string;
    end
  end

  lur_table #(
    .POS_BITS  (POS_BITS),
    .CHAR_BITS (CHAR_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (CHAR_BITS'(in_data.char_code)),
    .ctrl     (ctrl),
    .wr_pos   (wr_pos),
    .seen     (seen),
    .last_pos (last_pos)
  );

  lur_track #(
    .POS_BITS (POS_BITS)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .commit        (s1_adv),
    .has_char      (s1_has_char),
    .end_of_string (s1_eos),
    .seen          (seen),
    .last_pos      (last_pos),
    .ctrl          (ctrl),
    .wr_pos        (wr_pos),
    .result        (result)
  );

  // Output register: load a result on a closing beat, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data <= result;
    end
  end

  `LUR_ASSERT_NEXT(a_result_loads, clk, rst, res_load, out_valid, "closing beat lost")
  `LUR_ASSERT_NEXT(a_result_drops, clk, rst, res_take && !res_load, !out_valid, "result repeated")
  `LUR_ASSERT_NOW(a_clear_on_close, clk, rst, ctrl.clr, res_load, "clear without closing beat")
  `LUR_ASSERT_RESET(a_reset_empty, clk, rst, !s1_valid && !out_valid, "reset left work in flight")

endmodule

// ===== tb/longest_unique_run_length_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// longest_unique_run_length_tb
// Self-checking bench for the longest unique run length block. A queue of
// strings drives the input side beat by beat. A last-seen table in the
// bench predicts each reported length, and every result beat is checked
// against it in order. Sender and receiver idle at random in two of the
// three phases. One long receiver hold-off backs the block up into its input.
// ---------------------------------------------------------------------------
module longest_unique_run_length_tb;
  import lur_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 1 << CHAR_BITS_DEF;
  localparam int unsigned CHAR_MASK    = TABLE_DEPTH - 1;
  localparam int unsigned POS_LIMIT    = (1 << POS_BITS_DEF) - 1;
  localparam int unsigned LENGTH_MAX   = (1 << OUT_W) - 1;
  localparam int unsigned PHASE_BEATS  = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STUCK_LIMIT  = 5000;

  // Traffic phases: who idles and how often.
  typedef enum int {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FULL_RATE
  } traffic_phase_e;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  longest_unique_run_length i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Beats waiting to be offered, and lengths waiting to come back.
  in_item_t       beats_to_send[$];
  out_item_t      expected_lengths[$];

  traffic_phase_e traffic_phase = PH_SLOW_SINK;
  int unsigned    send_idle_pct = 12;
  int unsigned    recv_idle_pct = 52;
  logic           beat_taken    = 1'b0;
  int unsigned    stuck_cycles  = 0;
  int unsigned    failures      = 0;
  int unsigned    hold_left     = 0;
  bit             hold_done     = 1'b0;

  // Predictor state: per byte value, whether it appeared in the current
  // string and at which position it was last taken.
  bit             char_seen[TABLE_DEPTH];
  int unsigned    char_last_pos[TABLE_DEPTH];
  int unsigned    window_head   = 0;
  int unsigned    chars_taken   = 0;
  int unsigned    best_run      = 0;
  bit             run_overflow  = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the sliding window by one beat; on a closing beat, queue the
  // length the block must report and forget the string.
  function automatic void predict_run_length(in_item_t beat);
    int unsigned code;
    int unsigned run;
    out_item_t   res;
    if (beat.has_char) begin
      code = beat.char_code & CHAR_MASK;
      if (chars_taken >= POS_LIMIT) begin
        // Position counter is full: drop the byte, keep the best so far.
        run_overflow = 1'b1;
      end else begin
        // A repeat only pulls the window in if it was seen inside it.
        if (char_seen[code] && char_last_pos[code] >= window_head) begin
          window_head = char_last_pos[code] + 1;
        end
        char_last_pos[code] = chars_taken;
        char_seen[code]     = 1'b1;
        run = chars_taken - window_head + 1;
        if (run > best_run) begin
          best_run = run;
        end
        chars_taken++;
      end
    end
    if (beat.end_of_string) begin
      // Saturate to the output width and flag it.
      res.longest_length = OUT_W'((best_run > LENGTH_MAX) ? LENGTH_MAX : best_run);
      res.overflow       = run_overflow || (best_run > LENGTH_MAX);
      expected_lengths.push_back(res);
      foreach (char_seen[i]) begin
        char_seen[i] = 1'b0;
      end
      window_head  = 0;
      chars_taken  = 0;
      best_run     = 0;
      run_overflow = 1'b0;
    end
  endfunction

  function automatic void queue_beat(logic [CHAR_W-1:0] code, bit has, bit eos);
    in_item_t beat;
    beat.char_code     = code;
    beat.has_char      = has;
    beat.end_of_string = eos;
    beats_to_send.push_back(beat);
  endfunction

  // One random string. Most are short over a narrow alphabet so that
  // repeats, and repeats from before the window, are common. Some use the
  // full byte range. Bare beats are sprinkled in as noise, and the string
  // closes either on its last byte or on a bare end beat.
  task automatic queue_random_string();
    int unsigned       n_chars;
    int unsigned       alpha;
    int unsigned       pick;
    logic [CHAR_W-1:0] base;
    bit                close_on_char;
    pick = $urandom_range(19);
    base = CHAR_W'($urandom_range(255));
    if (pick == 0) begin
      n_chars = 0;
      alpha   = 1;
    end else if (pick <= 15) begin
      n_chars = $urandom_range(24, 1);
      alpha   = 1 << $urandom_range(5, 1);
    end else if (pick <= 18) begin
      n_chars = $urandom_range(80, 20);
      alpha   = TABLE_DEPTH;
    end else begin
      n_chars = $urandom_range(320, 200);
      alpha   = TABLE_DEPTH;
    end
    close_on_char = (n_chars > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(15) == 0) begin
        queue_beat(CHAR_W'($urandom), 1'b0, 1'b0);
      end
      queue_beat(base + CHAR_W'($urandom_range(alpha - 1)), 1'b1,
                 close_on_char && (i == n_chars - 1));
    end
    if (!close_on_char) begin
      queue_beat(CHAR_W'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Driver: present a new beat at the falling edge once the previous one
  // has been taken; hold the payload while the block stalls.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= beats_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when full-rate traffic
  // starts, so that a finished result sits in the output register while the
  // next closing beat backs up behind it.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (traffic_phase == PH_FULL_RATE && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: sample both channels at the rising edge. Feed accepted input
  // beats to the predictor and check accepted result beats in order.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      beat_taken   <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      beat_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        predict_run_length(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_lengths.size() == 0) begin
          $error("result beat with no string closed: longest_length=%0d overflow=%0b",
                 out_data.longest_length, out_data.overflow);
          failures++;
        end else begin
          want = expected_lengths.pop_front();
          if (out_data.longest_length !== want.longest_length) begin
            $error("longest_length: expected %0d, got %0d",
                   want.longest_length, out_data.longest_length);
            failures++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
            failures++;
          end
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] step;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty strings: a bare end beat, and a bare beat followed by one.
    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat(8'hA5, 1'b0, 1'b0);
    queue_beat(8'h5A, 1'b0, 1'b1);
    // One byte that also closes the string.
    queue_beat(8'h00, 1'b1, 1'b1);
    // Same top byte twice.
    queue_beat(8'hFF, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b1);
    // Classic sliding case: best of 3.
    queue_beat(8'h61, 1'b1, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b0);
    queue_beat(8'h61, 1'b1, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b1);
    // Repeat from before the window must not pull the window back: 2.
    queue_beat(8'h61, 1'b1, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h61, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b1);
    // Window moves past the middle repeat: 3.
    queue_beat(8'h64, 1'b1, 1'b0);
    queue_beat(8'h76, 1'b1, 1'b0);
    queue_beat(8'h64, 1'b1, 1'b0);
    queue_beat(8'h66, 1'b1, 1'b1);

    while (beats_to_send.size() < PHASE_BEATS) queue_random_string();
    while (beats_to_send.size() > 0) @(posedge clk);

    traffic_phase = PH_SLOW_SOURCE;
    send_idle_pct = 52;
    recv_idle_pct = 12;
    while (beats_to_send.size() < PHASE_BEATS) queue_random_string();
    while (beats_to_send.size() > 0) @(posedge clk);

    // Full rate; the receiver hold-off fires at the start of this phase.
    traffic_phase = PH_FULL_RATE;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (beats_to_send.size() < PHASE_BEATS - 50) queue_random_string();
    // Every byte value once (odd stride walks all 256), then a repeat of
    // the first: the run covers the whole table.
    base = CHAR_W'($urandom_range(255));
    step = CHAR_W'(2 * $urandom_range(127) + 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      queue_beat(base + CHAR_W'(i) * step, 1'b1, 1'b0);
    end
    queue_beat(base, 1'b1, 1'b1);
    // A random string after it to prove the tables were cleared.
    queue_random_string();

    while (beats_to_send.size() > 0 || in_valid) @(posedge clk);
    while (expected_lengths.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lur_pkg.sv
rtl/lur_table.sv
rtl/lur_track.sv
rtl/longest_unique_run_length.sv
tb/longest_unique_run_length_tb.sv
